@@ rtl/core/rta_pkg.sv @@
`timescale 1ns / 1ps
package rta_pkg;
  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_USED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_ALIGNED = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_NOSLOT   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] region_start;
    logic [31:0] request_length;
    logic [31:0] align_mask;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [2:0]  status;
    logic [31:0] free_bytes_now;
  } rsp_t;

  // One table entry as stored in memory
  typedef struct packed {
    kind_t       kind;
    logic [31:0] base;
    logic [31:0] size;
  } entry_t;
endpackage

@@ rtl/core/rta_table.sv @@
`timescale 1ns / 1ps
// Entry table: one write port, one registered read port; valid bits give
// the empty reset value without a clearing pass.
module rta_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [rta_pkg::IdxW-1:0] waddr,
  input  rta_pkg::entry_t          wdata,
  input  logic [rta_pkg::IdxW-1:0] raddr,
  output rta_pkg::entry_t          rdata
);
  rta_pkg::entry_t mem [rta_pkg::TableEntries];
  logic [rta_pkg::TableEntries-1:0] valid;
  rta_pkg::entry_t rd_raw;
  logic rd_valid;

  // write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw <= mem[raddr];
  end

  // track written entries; a read during a write returns the old word
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  // unwritten entries read as empty
  always_comb begin
    rdata = rd_valid ? rd_raw : '{kind: rta_pkg::KIND_EMPTY, base: '0, size: '0};
  end
endmodule

@@ rtl/core/rta_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: scans the table one entry per cycle and applies the command.
module rta_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  rta_pkg::req_t            req,
  output logic                     busy,
  output logic                     done,
  output rta_pkg::rsp_t            rsp,
  output logic                     we,
  output logic [rta_pkg::IdxW-1:0] waddr,
  output rta_pkg::entry_t          wdata,
  output logic [rta_pkg::IdxW-1:0] raddr,
  input  rta_pkg::entry_t          rdata
);
  localparam logic [rta_pkg::IdxW-1:0] LastIdx = rta_pkg::IdxW'(rta_pkg::TableEntries - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN1, S_DEC1, S_W1, S_W2, S_W3, S_SCAN2, S_MERGE, S_M1, S_M2, S_DONE
  } state_t;

  state_t state;
  rta_pkg::req_t r;
  logic [rta_pkg::IdxW:0] ridx;      // read address issued, one ahead
  logic [rta_pkg::IdxW-1:0] cidx;    // index of rdata
  logic rvalid;
  // first scan results
  logic hit; logic [rta_pkg::IdxW-1:0] hidx; rta_pkg::entry_t hent;
  logic [32:0] hal;                  // aligned start of hit
  logic [1:0] nempty; logic [rta_pkg::IdxW-1:0] e0, e1;
  // merge
  logic [rta_pkg::IdxW-1:0] mk; logic [32:0] mlo, mhi;
  logic bfound, afound; logic [rta_pkg::IdxW-1:0] bidx, aidx;
  logic [32:0] blo, ahi;
  logic [31:0] cnt;
  logic [31:0] addr; logic [2:0] st;
  logic [31:0] clen;
  logic [32:0] inc, aa, rend, alen;
  logic fit;

  assign busy = (state != S_IDLE);
  assign raddr = ridx[rta_pkg::IdxW-1:0];

  // candidate test on the entry just read
  always_comb begin
    inc  = {1'b0, r.align_mask} + 33'd1;
    aa   = {1'b0, rdata.base & ~r.align_mask} + inc;
    rend = {1'b0, rdata.base} + {1'b0, rdata.size};
    alen = rend - aa;
    fit  = 1'b0;
    if (rdata.kind == rta_pkg::KIND_FREE && rdata.size >= r.request_length) begin
      case (rta_pkg::cmd_t'(r.command))
        rta_pkg::CMD_ALLOC: fit = 1'b1;
        rta_pkg::CMD_ALIGNED: begin
          if ({1'b0, rdata.base} >= inc) begin
            fit = ((rdata.base & r.align_mask) == 32'd0) ||
                  (aa <= rend && alen >= {1'b0, r.request_length});
          end
        end
        default: fit = 1'b0;
      endcase
    end
    if (r.command == rta_pkg::CMD_FREE) begin
      fit = rdata.kind == rta_pkg::KIND_USED && rdata.base == r.region_start;
    end
  end

  // sequence the command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      we <= 1'b0;
      cnt <= '0;
      ridx <= '0;
      rvalid <= 1'b0;
    end else begin
      done <= 1'b0;
      we <= 1'b0;
      rvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            clen <= (req.request_length > (32'hFFFF_FFFF - req.region_start)) ?
                    32'hFFFF_FFFF - req.region_start : req.request_length;
            hit <= 1'b0; nempty <= 2'd0; addr <= '0; st <= rta_pkg::ST_OK;
            ridx <= '0;
            state <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          // issue one read per cycle, inspect the previous one
          if (!ridx[rta_pkg::IdxW]) begin
            cidx <= ridx[rta_pkg::IdxW-1:0];
            ridx <= ridx + 1'b1;
            rvalid <= 1'b1;
          end
          if (rvalid) begin
            if (rdata.kind == rta_pkg::KIND_EMPTY && nempty != 2'd2) begin
              if (nempty == 2'd0) e0 <= cidx; else e1 <= cidx;
              nempty <= nempty + 2'd1;
            end
            if (!hit && fit && r.request_length != 32'd0 || !hit && fit &&
                r.command == rta_pkg::CMD_FREE) begin
              hit <= 1'b1; hidx <= cidx; hent <= rdata; hal <= aa;
            end
          end
          if (rvalid && cidx == LastIdx) begin
            state <= S_DEC1;
          end
        end
        S_DEC1: begin
          state <= S_DONE;
          case (rta_pkg::cmd_t'(r.command))
            rta_pkg::CMD_ADD: begin
              if (clen != 32'd0) begin
                if (nempty == 2'd0) st <= rta_pkg::ST_FULL;
                else begin
                  we <= 1'b1; waddr <= e0;
                  wdata <= '{kind: rta_pkg::KIND_FREE, base: r.region_start, size: clen};
                  cnt <= ({1'b0, cnt} + {1'b0, clen} > 33'hFFFF_FFFF) ?
                         32'hFFFF_FFFF : cnt + clen;
                end
              end
            end
            rta_pkg::CMD_FREE: begin
              if (!hit) st <= rta_pkg::ST_NOTFOUND;
              else begin
                cnt <= ({1'b0, cnt} + {1'b0, hent.size} > 33'hFFFF_FFFF) ?
                       32'hFFFF_FFFF : cnt + hent.size;
                mk <= hidx; mlo <= {1'b0, hent.base};
                mhi <= {1'b0, hent.base} + {1'b0, hent.size};
                state <= S_MERGE;
              end
            end
            default: begin
              if (!hit) st <= rta_pkg::ST_NOFIT;
              else if ((r.command == rta_pkg::CMD_ALLOC) ||
                       ((hent.base & r.align_mask) == 32'd0)) begin
                // plain take from the front
                if (hent.size == r.request_length) begin
                  we <= 1'b1; waddr <= hidx;
                  wdata <= '{kind: rta_pkg::KIND_USED, base: hent.base, size: hent.size};
                  addr <= hent.base;
                  cnt <= (cnt > r.request_length) ? cnt - r.request_length : 32'd0;
                end else if (nempty == 2'd0) st <= rta_pkg::ST_NOSLOT;
                else begin
                  we <= 1'b1; waddr <= e0;
                  wdata <= '{kind: rta_pkg::KIND_USED, base: hent.base,
                             size: r.request_length};
                  addr <= hent.base;
                  cnt <= (cnt > r.request_length) ? cnt - r.request_length : 32'd0;
                  state <= S_W1;
                end
              end else begin
                // aligned with a gap
                if (nempty == 2'd0 || (hal + {1'b0, r.request_length} !=
                    {1'b0, hent.base} + {1'b0, hent.size} && nempty != 2'd2)) begin
                  st <= rta_pkg::ST_NOSLOT;
                end else begin
                  we <= 1'b1; waddr <= e0;
                  wdata <= '{kind: rta_pkg::KIND_FREE, base: hent.base,
                             size: hal[31:0] - hent.base};
                  addr <= hal[31:0];
                  cnt <= (cnt > r.request_length) ? cnt - r.request_length : 32'd0;
                  state <= S_W2;
                end
              end
            end
          endcase
        end
        S_W1: begin
          // shrink the source entry
          we <= 1'b1; waddr <= hidx;
          wdata <= '{kind: rta_pkg::KIND_FREE, base: hent.base + r.request_length,
                     size: hent.size - r.request_length};
          state <= S_DONE;
        end
        S_W2: begin
          if (hal + {1'b0, r.request_length} == {1'b0, hent.base} + {1'b0, hent.size}) begin
            we <= 1'b1; waddr <= hidx;
            wdata <= '{kind: rta_pkg::KIND_USED, base: hal[31:0], size: r.request_length};
            state <= S_M2;
          end else begin
            we <= 1'b1; waddr <= e1;
            wdata <= '{kind: rta_pkg::KIND_USED, base: hal[31:0], size: r.request_length};
            state <= S_W3;
          end
        end
        S_W3: begin
          we <= 1'b1; waddr <= hidx;
          wdata <= '{kind: rta_pkg::KIND_FREE, base: hal[31:0] + r.request_length,
                     size: hent.base + hent.size - hal[31:0] - r.request_length};
          state <= S_M2;
        end
        S_M2: begin
          // merge the gap entry
          mk <= e0; mlo <= {1'b0, hent.base}; mhi <= hal;
          state <= S_MERGE;
        end
        S_MERGE: begin
          bfound <= 1'b0; afound <= 1'b0;
          ridx <= '0;
          state <= S_SCAN2;
        end
        S_SCAN2: begin
          if (!ridx[rta_pkg::IdxW]) begin
            cidx <= ridx[rta_pkg::IdxW-1:0];
            ridx <= ridx + 1'b1;
            rvalid <= 1'b1;
          end
          if (rvalid && cidx != mk && rdata.kind == rta_pkg::KIND_FREE) begin
            if (!bfound && rend == mlo) begin
              bfound <= 1'b1; bidx <= cidx; blo <= {1'b0, rdata.base};
            end
            if (!afound && {1'b0, rdata.base} == mhi) begin
              afound <= 1'b1; aidx <= cidx; ahi <= rend;
            end
          end
          if (rvalid && cidx == LastIdx) begin
            state <= S_M1;
          end
        end
        S_M1: begin
          // clear neighbours, then write merged entry
          if (bfound) begin
            we <= 1'b1; waddr <= bidx;
            wdata <= '{kind: rta_pkg::KIND_EMPTY, base: '0, size: '0};
            mlo <= blo; bfound <= 1'b0;
          end else if (afound) begin
            we <= 1'b1; waddr <= aidx;
            wdata <= '{kind: rta_pkg::KIND_EMPTY, base: '0, size: '0};
            mhi <= ahi; afound <= 1'b0;
          end else begin
            we <= 1'b1; waddr <= mk;
            wdata <= '{kind: rta_pkg::KIND_FREE, base: mlo[31:0],
                       size: mhi[31:0] - mlo[31:0]};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          rsp.granted_address <= (st == rta_pkg::ST_OK) ? addr : 32'd0;
          rsp.status <= st;
          rsp.free_bytes_now <= cnt;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/region_table_allocator.sv @@
`timescale 1ns / 1ps
// Channel   Ports                     Handshake
// command   start, busy, cmd_word     taken when start && !busy
// result    done, result_word         one cycle strobe, no stall
// Each command scans the entry table once, one entry per cycle over the
// single table read port; free and aligned allocate with a gap scan a
// second time for merging.
// Reset is synchronous; the table reads as empty right after reset.
// busy stays high until the result strobe; the receiver cannot stall.
module region_table_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rta_pkg::req_t cmd_word,
  output logic          busy,
  output logic          done,
  output rta_pkg::rsp_t result_word
);
  logic we;
  logic [rta_pkg::IdxW-1:0] waddr, raddr;
  rta_pkg::entry_t wdata, rdata;

  rta_table u_table (
    .clk(clk), .rst(rst), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  rta_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req(cmd_word), .busy(busy),
    .done(done), .rsp(result_word), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // a result ends every busy period
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command not taken");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> result_word.status <= rta_pkg::ST_FULL) else $error("bad status");
  a_addr: assert property (@(posedge clk) disable iff (rst)
    done && result_word.status != rta_pkg::ST_OK |-> result_word.granted_address == 32'd0)
    else $error("address on error");
endmodule
